@@ hw/rtl/sssp_pkg.sv @@
// Shared types, sizes and codes for the shortest-path engine.
// Used by sssp_alu, sssp_wstore and single_source_shortest_paths.
`default_nettype none
package sssp_pkg;

  // Built sizes
  localparam int MAX_VERTICES = 16;
  localparam int WEIGHT_BITS  = 16;
  localparam int DIST_BITS    = 24;

  // Derived widths
  localparam int VIDX_W     = $clog2(MAX_VERTICES);
  localparam int NW         = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W     = 2 * VIDX_W;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int SUM_W      = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
  localparam int EDGE_CNT_W = 9;

  // Port field widths
  localparam int IN_VIDX_W  = 6;
  localparam int IN_W_W     = 16;
  localparam int OUT_VIDX_W = 6;
  localparam int OUT_DIST_W = 24;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;

  localparam logic [WEIGHT_BITS-1:0] W_MAX = '1;
  localparam logic [DIST_BITS-1:0]   D_MAX = '1;

  // Request codes carried in tuser; the fourth code does nothing
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_CLEAR = 2'd2
  } req_code_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VTOTAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ERR,
    ST_SCAN,
    ST_PICK,
    ST_REL_RD,
    ST_REL_UPD,
    ST_EMIT
  } state_t;

  // Request to the weight store
  typedef struct packed {
    logic                   rd;
    logic                   wr;
    logic                   clr;
    logic                   fresh;   // write creates a new edge
    logic [ADDR_W-1:0]      addr;
    logic [WEIGHT_BITS-1:0] wdata;
  } wst_req_t;

  // Answer from the weight store
  typedef struct packed {
    logic                   present;
    logic [WEIGHT_BITS-1:0] rdata;
    logic                   empty;   // no edge stored
  } wst_rsp_t;

  // Saturate an incoming weight to the stored width
  function automatic logic [WEIGHT_BITS-1:0] sat_weight(input logic [IN_W_W-1:0] w);
    logic [32:0] wide;
    wide = 33'(w);
    if (wide > 33'(W_MAX)) return W_MAX;
    return WEIGHT_BITS'(w);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/single_source_shortest_paths.sv @@
// Shortest-path engine top level: sequencer, distance registers, output stage.
// Depends on sssp_pkg, sssp_alu and sssp_wstore.
//
// Use:
//   Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser. tuser carries the
//   request: load an edge, run, or clear the graph. Results leave on
//   m_tvalid/m_tready/m_tdata/m_tlast, one per vertex of a run, tlast on the
//   final one. A run with no vertices or no stored edge gives one item with
//   status set. The user must write registers source_vertex and vertex_total
//   via cfg_we/cfg_index/cfg_data only while the engine is idle; not enforced.
// Sequence:
//   A load reads the weight memory, then compares and writes back; a load
//   with an endpoint beyond the built size, a clear or an unused code is
//   handled in idle. A run of n vertices scans, picks and relaxes for each
//   reachable vertex, then scans once more; its n results are then offered,
//   one per cycle while the receiver is ready. The minimum scan and the edge
//   relaxation share the one add-and-compare unit, and each relaxation step
//   waits for its registered weight memory read. s_tready is high only in idle.
// Reset clears the graph, the marks and the registers to their defaults at
// once. A stalled receiver holds the output register; the engine accepts the
// next item behind it and a new run waits before its first result.
`default_nettype none
module single_source_shortest_paths (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [31:0]                s_tdata,  // edge_from, edge_to, edge_weight, 4'b0
  input  wire logic [1:0]                 s_tuser,  // req_type
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [31:0]                     m_tdata,  // vertex_index, distance, reachable, status
  output logic                            m_tlast,
  input  wire logic                       cfg_we,
  input  wire logic [sssp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sssp_pkg::CFG_W-1:0] cfg_data
);
  import sssp_pkg::*;

  // Input fields
  logic [IN_VIDX_W-1:0] in_from;
  logic [IN_VIDX_W-1:0] in_to;
  logic [IN_W_W-1:0]    in_weight;
  logic                 in_range;
  logic                 accept;

  assign in_from   = s_tdata[5:0];
  assign in_to     = s_tdata[11:6];
  assign in_weight = s_tdata[27:12];
  assign in_range  = (7'(in_from) < 7'(MAX_VERTICES)) && (7'(in_to) < 7'(MAX_VERTICES));
  assign accept    = s_tvalid && s_tready;

  // Configuration
  logic [IN_VIDX_W-1:0] source_vertex;
  logic [CFG_W-1:0]     vertex_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_vertex <= '0;
      vertex_total  <= CFG_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOURCE: source_vertex <= cfg_data[IN_VIDX_W-1:0];
        CFG_VTOTAL: vertex_total  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NW-1:0] n_start;
  logic          src_ok;
  assign n_start = (vertex_total > CFG_W'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                         : NW'(vertex_total);
  assign src_ok  = 7'(source_vertex) < 7'(n_start);

  // Sequencer and datapath state
  state_t state, state_next;

  logic [DIST_BITS-1:0]    vdist [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] reach;
  logic [MAX_VERTICES-1:0] settled;
  logic [VIDX_W-1:0]       idx;      // scan, emit counter
  logic [VIDX_W-1:0]       vtx;      // relaxation counter
  logic [VIDX_W-1:0]       u_sel;
  logic                    found;
  logic [DIST_BITS-1:0]    best;
  logic [NW-1:0]           n_reg;
  logic [ADDR_W-1:0]       ld_addr;
  logic [WEIGHT_BITS-1:0]  ld_w;

  logic idx_last, vtx_last, out_free, cand, do_relax;
  assign idx_last = (NW'(idx) + NW'(1)) == n_reg;
  assign vtx_last = (NW'(vtx) + NW'(1)) == n_reg;
  assign out_free = !m_tvalid || m_tready;

  // Shared add-and-compare unit
  logic [DIST_BITS-1:0]   alu_base, alu_cmp, alu_sum;
  logic [WEIGHT_BITS-1:0] alu_add;
  logic                   alu_less;

  sssp_alu u_alu (
    .base    (alu_base),
    .addend  (alu_add),
    .cmp_val (alu_cmp),
    .sum     (alu_sum),
    .less    (alu_less)
  );

  // Weight store
  wst_req_t wreq;
  wst_rsp_t wrsp;

  sssp_wstore u_wstore (
    .clk (clk),
    .rst (rst),
    .req (wreq),
    .rsp (wrsp)
  );

  // Operand selection: scan compares vdist[idx] with the best so far,
  // relaxation adds the edge weight to the settled distance.
  always_comb begin
    if (state == ST_REL_UPD) begin
      alu_base = best;
      alu_add  = wrsp.rdata;
      alu_cmp  = vdist[vtx];
    end else begin
      alu_base = vdist[idx];
      alu_add  = '0;
      alu_cmp  = best;
    end
  end

  assign cand     = reach[idx] && !settled[idx] && (!found || alu_less);
  assign do_relax = wrsp.present && !settled[vtx] && (!reach[vtx] || alu_less);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && s_tuser == REQ_LOAD && in_range) begin
          state_next = ST_LOAD;
        end else if (accept && s_tuser == REQ_RUN) begin
          state_next = (n_start == '0 || wrsp.empty) ? ST_ERR : ST_SCAN;
        end
      end
      ST_LOAD:    state_next = ST_IDLE;
      ST_ERR:     if (out_free) state_next = ST_IDLE;
      ST_SCAN:    if (idx_last) state_next = ST_PICK;
      ST_PICK:    state_next = found ? ST_REL_RD : ST_EMIT;
      ST_REL_RD:  state_next = ST_REL_UPD;
      ST_REL_UPD: state_next = vtx_last ? ST_SCAN : ST_REL_RD;
      ST_EMIT:    if (out_free && idx_last) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  logic ld_fresh, ld_lower;
  assign ld_fresh = !wrsp.present;
  assign ld_lower = ld_w < wrsp.rdata;

  always_comb begin
    s_tready   = 1'b0;
    wreq       = '0;
    wreq.wdata = ld_w;
    wreq.addr  = ld_addr;
    unique case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        // read the old weight while the load item is taken
        wreq.addr = {in_from[VIDX_W-1:0], in_to[VIDX_W-1:0]};
        wreq.rd   = s_tvalid && s_tuser == REQ_LOAD && in_range;
        wreq.clr  = s_tvalid && s_tuser == REQ_CLEAR;
      end
      ST_LOAD: begin
        wreq.wr    = ld_fresh || ld_lower;
        wreq.fresh = ld_fresh;
      end
      ST_REL_RD: begin
        wreq.addr = {u_sel, vtx};
        wreq.rd   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reach   <= '0;
      settled <= '0;
      found   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && s_tuser == REQ_RUN) begin
            // only the source starts out reached
            reach   <= src_ok ? (MAX_VERTICES'(1) << source_vertex[VIDX_W-1:0]) : '0;
            settled <= '0;
            found   <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (cand) found <= 1'b1;
        end
        ST_PICK: begin
          if (found) settled[u_sel] <= 1'b1;
        end
        ST_REL_UPD: begin
          if (do_relax) reach[vtx] <= 1'b1;
          if (vtx_last) found <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ld_addr <= {in_from[VIDX_W-1:0], in_to[VIDX_W-1:0]};
          ld_w    <= sat_weight(in_weight);
          n_reg   <= n_start;
          idx     <= '0;
          if (src_ok) begin
            vdist[source_vertex[VIDX_W-1:0]] <= '0;
          end
        end
      end
      ST_SCAN: begin
        if (cand) begin
          best  <= vdist[idx];
          u_sel <= idx;
        end
        // restart at vertex zero for the emit pass or the next scan
        idx <= idx_last ? '0 : idx + VIDX_W'(1);
      end
      ST_PICK: begin
        vtx <= '0;
      end
      ST_REL_UPD: begin
        if (do_relax) vdist[vtx] <= alu_sum;
        vtx <= vtx + VIDX_W'(1);
      end
      ST_EMIT: begin
        if (out_free) idx <= idx + VIDX_W'(1);
      end
      default: ;
    endcase
  end

  // Output register
  logic                  load_out;
  logic [DIST_BITS-1:0]  emit_dist;
  assign load_out  = out_free && (state == ST_EMIT || state == ST_ERR);
  assign emit_dist = reach[idx] ? vdist[idx] : D_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == ST_ERR) begin
        m_tdata <= {1'b1, 1'b0, OUT_DIST_W'(0), OUT_VIDX_W'(0)};
        m_tlast <= 1'b1;
      end else begin
        m_tdata <= {1'b0, reach[idx], OUT_DIST_W'(emit_dist), OUT_VIDX_W'(idx)};
        m_tlast <= idx_last;
      end
    end
  end

  // A vertex is settled only once it has been reached
  a_settled_reached: assert property (@(posedge clk) disable iff (rst)
    (settled & ~reach) == '0)
    else $error("settled vertex without a distance");

  // The scan never walks past the vertices in use
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_EMIT) |-> (NW'(idx) < n_reg))
    else $error("vertex counter beyond vertex count");

  // The final result of a run returns the engine to idle with tlast set
  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free && idx_last) |=> (state == ST_IDLE && m_tvalid && m_tlast))
    else $error("run did not finish after its final result");

  // A relaxation step always follows its weight read
  a_rel_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REL_UPD) |-> $past(state == ST_REL_RD))
    else $error("relaxation without a weight read");

endmodule
`default_nettype wire

@@ hw/rtl/sssp_alu.sv @@
// Shared add-and-compare unit: saturating distance add, then a less-than test.
// Depends on sssp_pkg.
`default_nettype none
module sssp_alu (
  input  wire logic [sssp_pkg::DIST_BITS-1:0]   base,
  input  wire logic [sssp_pkg::WEIGHT_BITS-1:0] addend,
  input  wire logic [sssp_pkg::DIST_BITS-1:0]   cmp_val,
  output logic      [sssp_pkg::DIST_BITS-1:0]   sum,
  output logic                                  less
);
  import sssp_pkg::*;

  logic [SUM_W-1:0] raw;

  always_comb begin
    raw  = SUM_W'(base) + SUM_W'(addend);
    sum  = (raw > SUM_W'(D_MAX)) ? D_MAX : DIST_BITS'(raw);
    less = sum < cmp_val;
  end
endmodule
`default_nettype wire

@@ hw/rtl/sssp_wstore.sv @@
// Weight matrix store: presence flags in flip-flops, weights in a memory,
// and the saturating count of distinct edges. Depends on sssp_pkg.
`default_nettype none
module sssp_wstore (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sssp_pkg::wst_req_t req,
  output sssp_pkg::wst_rsp_t      rsp
);
  import sssp_pkg::*;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]       present;
  logic [EDGE_CNT_W-1:0]  edge_cnt;
  logic [WEIGHT_BITS-1:0] rdata;
  logic                   rpresent;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present  <= '0;
      edge_cnt <= '0;
      rpresent <= 1'b0;
    end else begin
      if (req.rd) begin
        rpresent <= present[req.addr];
      end
      if (req.clr) begin
        present  <= '0;
        edge_cnt <= '0;
      end else if (req.wr) begin
        present[req.addr] <= 1'b1;
        if (req.fresh && edge_cnt != '1) begin
          edge_cnt <= edge_cnt + EDGE_CNT_W'(1);
        end
      end
    end
  end

  assign rsp.present = rpresent;
  assign rsp.rdata   = rdata;
  assign rsp.empty   = (edge_cnt == '0);
endmodule
`default_nettype wire
